/* design/cpfh_pkg.sv */
package cpfh_pkg;

  localparam int FRAC_BITS_DEF = 16;

  typedef struct packed {
    logic signed [31:0] h00;
    logic signed [31:0] h10;
    logic signed [31:0] h20;
    logic signed [31:0] h01;
    logic signed [31:0] h11;
    logic signed [31:0] h21;
    logic signed [31:0] h02;
    logic signed [31:0] h12;
    logic signed [31:0] h22;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] r00;
    logic signed [31:0] r10;
    logic signed [31:0] r20;
    logic signed [31:0] r01;
    logic signed [31:0] r11;
    logic signed [31:0] r21;
    logic signed [31:0] r02;
    logic signed [31:0] r12;
    logic signed [31:0] r22;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } out_item_t;

  // magnitude of a signed word; -2^31 maps to 2^31
  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

  // apply sign to a magnitude and clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat_signed(input logic [32:0] q,
                                                    input logic big,
                                                    input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = (big || q > 33'h080000000) ? 32'sh80000000 : $signed(32'd0 - q[31:0]);
    end else begin
      r = (big || q > 33'h07fffffff) ? 32'sh7fffffff : $signed(q[31:0]);
    end
    return r;
  endfunction

endpackage

/* design/camera_pose_from_homography_unit.sv */
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_valid/in_stall  | in_data  (cpfh_pkg::in_item_t, 9 x Q16.16)
// out_    | out | out_valid/out_stall| out_data (cpfh_pkg::out_item_t, 12 x Q16.16)
//
// One homography per cycle unless a held result stalls it; stages: squares, sum,
// 32-stage square root, 35-stage divider lanes (nine in parallel), cross product merge, output reg.
// Reset (sync, active low) clears only the beat valid pipeline.
// A held result at the output freezes the whole pipeline; in_stall follows it.
module camera_pose_from_homography_unit #(
  parameter int FRAC_BITS = cpfh_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cpfh_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cpfh_pkg::out_item_t out_data
);

  localparam int LAT = 71;
  localparam int HD  = 34;

  logic en;
  logic [LAT-1:0] vld_r;

  logic [63:0] sq_r [6];
  logic [63:0] sum_r [2];
  logic [31:0] n0, n1;
  cpfh_pkg::in_item_t hd_r [HD];

  logic signed [31:0] hv  [9];
  logic [32:0]        den [9];
  logic signed [31:0] dq  [9];

  logic signed [31:0] u0 [3];
  logic signed [31:0] u1 [3];
  logic signed [31:0] cr [3];
  logic signed [31:0] ud_r [9];
  cpfh_pkg::out_item_t out_r;

  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign out_valid = vld_r[LAT-1];
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= 64'(cpfh_pkg::mag32(in_data.h00)) * 64'(cpfh_pkg::mag32(in_data.h00));
      sq_r[1] <= 64'(cpfh_pkg::mag32(in_data.h10)) * 64'(cpfh_pkg::mag32(in_data.h10));
      sq_r[2] <= 64'(cpfh_pkg::mag32(in_data.h20)) * 64'(cpfh_pkg::mag32(in_data.h20));
      sq_r[3] <= 64'(cpfh_pkg::mag32(in_data.h01)) * 64'(cpfh_pkg::mag32(in_data.h01));
      sq_r[4] <= 64'(cpfh_pkg::mag32(in_data.h11)) * 64'(cpfh_pkg::mag32(in_data.h11));
      sq_r[5] <= 64'(cpfh_pkg::mag32(in_data.h21)) * 64'(cpfh_pkg::mag32(in_data.h21));
      sum_r[0] <= sq_r[0] + sq_r[1] + sq_r[2];
      sum_r[1] <= sq_r[3] + sq_r[4] + sq_r[5];
      hd_r[0] <= in_data;
      for (int k = 1; k < HD; k++) begin
        hd_r[k] <= hd_r[k-1];
      end
    end
  end

  cpfh_sqrt u_sqrt0 (.clk(clk), .en(en), .v(sum_r[0]), .n(n0));
  cpfh_sqrt u_sqrt1 (.clk(clk), .en(en), .v(sum_r[1]), .n(n1));

  assign hv[0] = hd_r[HD-1].h00;
  assign hv[1] = hd_r[HD-1].h10;
  assign hv[2] = hd_r[HD-1].h20;
  assign hv[3] = hd_r[HD-1].h01;
  assign hv[4] = hd_r[HD-1].h11;
  assign hv[5] = hd_r[HD-1].h21;
  assign hv[6] = hd_r[HD-1].h02;
  assign hv[7] = hd_r[HD-1].h12;
  assign hv[8] = hd_r[HD-1].h22;

  for (genvar i = 0; i < 9; i++) begin : g_lane
    if (i < 3) begin : g_c0
      assign den[i] = {1'b0, n0};
      cpfh_div #(.SH(FRAC_BITS)) u_div (
        .clk(clk), .en(en), .mag(cpfh_pkg::mag32(hv[i])), .neg(hv[i][31]),
        .den(den[i]), .res(dq[i])
      );
    end else if (i < 6) begin : g_c1
      assign den[i] = {1'b0, n1};
      cpfh_div #(.SH(FRAC_BITS)) u_div (
        .clk(clk), .en(en), .mag(cpfh_pkg::mag32(hv[i])), .neg(hv[i][31]),
        .den(den[i]), .res(dq[i])
      );
    end else begin : g_c2
      // mean length kept exact: divide by n0 + n1 with one extra shift
      assign den[i] = {1'b0, n0} + {1'b0, n1};
      cpfh_div #(.SH(FRAC_BITS + 1)) u_div (
        .clk(clk), .en(en), .mag(cpfh_pkg::mag32(hv[i])), .neg(hv[i][31]),
        .den(den[i]), .res(dq[i])
      );
    end
  end

  assign u0[0] = dq[0];
  assign u0[1] = dq[1];
  assign u0[2] = dq[2];
  assign u1[0] = dq[3];
  assign u1[1] = dq[4];
  assign u1[2] = dq[5];

  cpfh_cross #(.FRAC_BITS(FRAC_BITS)) u_cross (
    .clk(clk), .en(en), .u0(u0), .u1(u1), .r(cr)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        ud_r[k] <= dq[k];
      end
      out_r.r00 <= ud_r[0];
      out_r.r10 <= ud_r[1];
      out_r.r20 <= ud_r[2];
      out_r.r01 <= ud_r[3];
      out_r.r11 <= ud_r[4];
      out_r.r21 <= ud_r[5];
      out_r.r02 <= cr[0];
      out_r.r12 <= cr[1];
      out_r.r22 <= cr[2];
      out_r.tx  <= ud_r[6];
      out_r.ty  <= ud_r[7];
      out_r.tz  <= ud_r[8];
    end
  end

endmodule

/* design/cpfh_sqrt.sv */
// Floor square root of a 64-bit value, one result bit per stage.
module cpfh_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v,
  output logic [31:0] n
);

  logic [63:0] rem_r  [32];
  logic [31:0] root_r [32];

  for (genvar k = 0; k < 32; k++) begin : g_stg
    localparam int B = 31 - k;
    logic [63:0] rem_in;
    logic [31:0] root_in;
    logic [65:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = v;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (2*root + 2^B) * 2^B, root holds only bits above B
    assign trial = ({34'd0, root_in} << (B + 1)) + (66'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({2'b00, rem_in} >= trial) begin
          rem_r[k]  <= rem_in - trial[63:0];
          root_r[k] <= root_in | (32'd1 << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign n = root_r[31];

endmodule

/* design/cpfh_div.sv */
// One divider lane: round(mag * 2^SH / den) with sign, saturated; zero when den is zero.
module cpfh_div #(
  parameter int SH = cpfh_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        mag,
  input  logic               neg,
  input  logic [32:0]        den,
  output logic signed [31:0] res
);

  localparam int NW = 33 + SH;
  localparam int W  = (NW > 66) ? NW : 66;
  localparam int QB = 33;

  typedef struct packed {
    logic ovf;
    logic zero;
    logic neg;
  } flags_t;

  logic [W-1:0]  num;
  logic [W-1:0]  prem_r;
  logic [32:0]   pden_r;
  flags_t        pflg_r;

  logic [W-1:0]  rem_r [QB];
  logic [QB-1:0] q_r   [QB];
  logic [32:0]   den_r [QB];
  flags_t        flg_r [QB];

  assign num = (W'(mag) << SH) + W'(den >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      prem_r      <= num;
      pden_r      <= den;
      pflg_r.ovf  <= (num >> QB) >= W'(den);
      pflg_r.zero <= (den == '0);
      pflg_r.neg  <= neg;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stg
    localparam int B = QB - 1 - k;
    logic [W-1:0]  rem_in;
    logic [QB-1:0] q_in;
    logic [32:0]   den_in;
    flags_t        flg_in;
    logic [W-1:0]  trial;

    if (k == 0) begin : g_first
      assign rem_in = prem_r;
      assign q_in   = '0;
      assign den_in = pden_r;
      assign flg_in = pflg_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign flg_in = flg_r[k-1];
    end

    assign trial = W'(den_in) << B;

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k] <= den_in;
        flg_r[k] <= flg_in;
        if (rem_in >= trial) begin
          rem_r[k] <= rem_in - trial;
          q_r[k]   <= q_in | (QB'(1) << B);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (flg_r[QB-1].zero) begin
        res <= '0;
      end else begin
        res <= cpfh_pkg::sat_signed(q_r[QB-1], flg_r[QB-1].ovf, flg_r[QB-1].neg);
      end
    end
  end

endmodule

/* design/cpfh_cross.sv */
// Merge stage: cross product of the two unit columns, rounded and saturated.
module cpfh_cross #(
  parameter int FRAC_BITS = cpfh_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] u0 [3],
  input  logic signed [31:0] u1 [3],
  output logic signed [31:0] r  [3]
);

  // products a*b and c*d per output component
  logic signed [63:0] pa_r [3];
  logic signed [63:0] pb_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      pa_r[0] <= u0[1] * u1[2];
      pb_r[0] <= u0[2] * u1[1];
      pa_r[1] <= u0[2] * u1[0];
      pb_r[1] <= u0[0] * u1[2];
      pa_r[2] <= u0[0] * u1[1];
      pb_r[2] <= u0[1] * u1[0];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_cmp
    logic signed [64:0] p;
    logic [64:0]        pm;
    logic [65:0]        q;

    assign p  = {pa_r[i][63], pa_r[i]} - {pb_r[i][63], pb_r[i]};
    assign pm = p[64] ? (65'd0 - p) : p;
    assign q  = ({1'b0, pm} + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    assign r[i] = cpfh_pkg::sat_signed(q[32:0], |q[65:33], p[64]);
  end

endmodule

/* verif/pose_checker.sv */
module pose_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  cpfh_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  cpfh_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending_poses
);

  localparam int FB = cpfh_pkg::FRAC_BITS_DEF;

  cpfh_pkg::out_item_t expected_poses[$];

  assign pending_poses = expected_poses.size();

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] isqrt(input logic [65:0] v);
    logic [65:0] rem;
    logic [65:0] root;
    logic [65:0] bitv;
    rem = v;
    root = '0;
    bitv = 66'd1 << 64;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[63:0];
  endfunction

  function automatic logic [63:0] col_norm(input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z);
    logic [65:0] s;
    logic [63:0] mx, my, mz;
    mx = mag64(64'(x));
    my = mag64(64'(y));
    mz = mag64(64'(z));
    s = 66'(mx * mx) + 66'(my * my) + 66'(mz * mz);
    return isqrt(s);
  endfunction

  function automatic logic signed [31:0] clamp_signed(input logic [95:0] q,
                                                      input logic neg);
    if (neg) return (q > 96'h80000000) ? 32'sh80000000 : 32'(96'd0 - q);
    return (q > 96'h7fffffff) ? 32'sh7fffffff : 32'(q);
  endfunction

  // round(h * 2^sh / den), ties away from zero
  function automatic logic signed [31:0] scaled_quot(input logic signed [31:0] h,
                                                      input int sh,
                                                      input logic [63:0] den);
    logic [95:0] num;
    if (den == 0) return 0;
    num = (96'(mag64(64'(h))) << sh) + 96'(den >> 1);
    return clamp_signed(num / 96'(den), h[31]);
  endfunction

  function automatic logic signed [31:0] cross_comp(input logic signed [31:0] a,
                                                     input logic signed [31:0] b,
                                                     input logic signed [31:0] c,
                                                     input logic signed [31:0] d);
    logic signed [65:0] p;
    logic [65:0] m;
    p = 66'(a) * 66'(b) - 66'(c) * 66'(d);
    m = p[65] ? (66'd0 - p) : p;
    m = (m + (66'd1 << (FB - 1))) >> FB;
    return clamp_signed(96'(m), p[65]);
  endfunction

  function automatic cpfh_pkg::out_item_t predict_pose(input cpfh_pkg::in_item_t h);
    cpfh_pkg::out_item_t r;
    logic [63:0] n0, n1, nsum;
    n0 = col_norm(h.h00, h.h10, h.h20);
    n1 = col_norm(h.h01, h.h11, h.h21);
    nsum = n0 + n1;
    r.r00 = scaled_quot(h.h00, FB, n0);
    r.r10 = scaled_quot(h.h10, FB, n0);
    r.r20 = scaled_quot(h.h20, FB, n0);
    r.r01 = scaled_quot(h.h01, FB, n1);
    r.r11 = scaled_quot(h.h11, FB, n1);
    r.r21 = scaled_quot(h.h21, FB, n1);
    r.r02 = cross_comp(r.r10, r.r21, r.r20, r.r11);
    r.r12 = cross_comp(r.r20, r.r01, r.r00, r.r21);
    r.r22 = cross_comp(r.r00, r.r11, r.r10, r.r01);
    r.tx = scaled_quot(h.h02, FB + 1, nsum);
    r.ty = scaled_quot(h.h12, FB + 1, nsum);
    r.tz = scaled_quot(h.h22, FB + 1, nsum);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name,
               $signed(exp_v), $signed(got_v));
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    cpfh_pkg::out_item_t e;
    if (rst_n && in_valid && !in_stall) begin
      expected_poses.insert(expected_poses.size(), predict_pose(in_data));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_poses.size() == 0) begin
        $display("%0t: unexpected pose beat %h", $time, out_data);
        fail_count++;
      end else begin
        e = expected_poses.pop_front();
        check_field("r00", e.r00, out_data.r00);
        check_field("r10", e.r10, out_data.r10);
        check_field("r20", e.r20, out_data.r20);
        check_field("r01", e.r01, out_data.r01);
        check_field("r11", e.r11, out_data.r11);
        check_field("r21", e.r21, out_data.r21);
        check_field("r02", e.r02, out_data.r02);
        check_field("r12", e.r12, out_data.r12);
        check_field("r22", e.r22, out_data.r22);
        check_field("tx", e.tx, out_data.tx);
        check_field("ty", e.ty, out_data.ty);
        check_field("tz", e.tz, out_data.tz);
      end
    end
  end
endmodule

/* verif/tb_top.sv */
module tb_top;

  localparam int LATENCY = 71;
  localparam int IDLE_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cpfh_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  cpfh_pkg::out_item_t out_data;
  int fail_count;
  int pending_poses;
  int idle_cycles;
  int stall_mode;

  camera_pose_from_homography_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  pose_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending_poses(pending_poses)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 0;
      3: return $signed($urandom_range(0, 2000)) - 1000;
      4: return $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
      5: return $signed($urandom) >>> $urandom_range(0, 31);
      default: return $signed($urandom_range(0, 32'h1000000)) - 32'sh800000;
    endcase
  endfunction

  function automatic cpfh_pkg::in_item_t rand_homography();
    cpfh_pkg::in_item_t h;
    h = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word(), rand_word(), rand_word(), rand_word()};
    if ($urandom_range(0, 15) == 0) {h.h00, h.h10, h.h20} = 96'd0;
    if ($urandom_range(0, 15) == 0) {h.h01, h.h11, h.h21} = 96'd0;
    return h;
  endfunction

  // receiver stall pattern: free-running, switching mode now and then
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("camera_pose_from_homography_unit verification failed");
      $finish;
    end
  end

  task automatic send_beat(input cpfh_pkg::in_item_t h);
    in_valid <= 1'b1;
    in_data <= h;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    cpfh_pkg::in_item_t d;
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, zero columns, zero mean length, huge translation
    send_beat('0);
    send_beat({9{32'sh7fffffff}});
    send_beat({9{32'sh80000000}});
    send_beat({9{32'sh00010000}});
    send_beat({9{32'shffff0000}});
    d = '0; d.h00 = 32'sh10000; d.h11 = 32'sh10000; d.h22 = 32'sh10000;
    send_beat(d);
    d = '0; d.h01 = 32'sh30000; d.h02 = 32'sh7fffffff;
    send_beat(d);
    d = '0; d.h20 = 1; d.h02 = 32'sh80000000; d.h12 = 32'sh7fffffff;
    send_beat(d);
    d = '0; d.h02 = 32'sh12345; d.h12 = -5; d.h22 = 32'sh80000000;
    send_beat(d);
    d = {32'sh80000000, 32'sh7fffffff, 32'sh1, 32'sh7fffffff, 32'sh80000000,
         32'shffffffff, 32'sh1, 32'sh1, 32'sh1};
    send_beat(d);
    d = {32'sh3, 32'sh4, 32'sh0, 32'sh0, 32'sh0, 32'sh5, 32'sh5555, 32'shaaaa,
         32'sh2};
    send_beat(d);
    d = {32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa,
         32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa};
    send_beat(d);
    send_beat(~d);
    pause_sender(1);

    // drain fully before random traffic
    while (pending_poses != 0) @(posedge clk);

    for (int i = 0; i < 1800; ) begin
      burst = $urandom_range(1, 40);
      for (int k = 0; k < burst && i < 1800; k++, i++) send_beat(rand_homography());
      if (i >= 900 && i < 900 + burst) begin
        in_valid <= 1'b0;
        while (pending_poses != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    in_valid <= 1'b0;

    while (pending_poses != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) $display("camera_pose_from_homography_unit verification clean");
    else $display("camera_pose_from_homography_unit verification failed");
    $finish;
  end
endmodule
